@@ src/hidkbd_pkg.sv @@
// shared types, constants and helpers for the keyboard report to key event block
package hidkbd_pkg;

  localparam int KEY_CODE_COUNT = 128;
  localparam int REPORT_SLOTS   = 6;
  localparam int CODE_W         = 8;
  localparam int KEY_W          = $clog2(KEY_CODE_COUNT);
  localparam int MOD_EVT_N      = 4;

  // key scan window
  localparam int WIN_W     = 16;
  localparam int NUM_WIN   = KEY_CODE_COUNT / WIN_W;
  localparam int WIN_IDX_W = $clog2(NUM_WIN);
  localparam int POS_W     = $clog2(WIN_W);

  // job queue, depth a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_COUNT  = 8;
  localparam int CFG_ADDR_W = $clog2(CFG_COUNT * 4);
  localparam int CFG_IDX_W  = $clog2(CFG_COUNT);
  localparam int APB_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODE_LEFT_CONTROL = 3'd0,
    REG_CODE_LEFT_SHIFT   = 3'd1,
    REG_CODE_RIGHT_SHIFT  = 3'd2,
    REG_CODE_LEFT_ALT     = 3'd3,
    REG_CODE_RIGHT        = 3'd4,
    REG_CODE_LEFT         = 3'd5,
    REG_CODE_DOWN         = 3'd6,
    REG_CODE_UP           = 3'd7
  } cfg_reg_e;

  localparam logic [CODE_W-1:0] RST_CODE_LEFT_CONTROL = 8'd224;
  localparam logic [CODE_W-1:0] RST_CODE_LEFT_SHIFT   = 8'd225;
  localparam logic [CODE_W-1:0] RST_CODE_RIGHT_SHIFT  = 8'd229;
  localparam logic [CODE_W-1:0] RST_CODE_LEFT_ALT     = 8'd226;
  localparam logic [6:0]        RST_CODE_RIGHT        = 7'd79;
  localparam logic [CODE_W-1:0] RST_CODE_LEFT         = 8'd80;
  localparam logic [6:0]        RST_CODE_DOWN         = 7'd81;
  localparam logic [CODE_W-1:0] RST_CODE_UP           = 8'd82;

  // modifier event slots, in emission order
  localparam int MOD_LCTRL  = 0;
  localparam int MOD_LSHIFT = 1;
  localparam int MOD_LALT   = 2;
  localparam int MOD_RSHIFT = 3;

  typedef struct packed {
    logic [CODE_W-1:0] code_left_control;
    logic [CODE_W-1:0] code_left_shift;
    logic [CODE_W-1:0] code_right_shift;
    logic [CODE_W-1:0] code_left_alt;
    logic [6:0]        code_right;
    logic [CODE_W-1:0] code_left;
    logic [6:0]        code_down;
    logic [CODE_W-1:0] code_up;
  } cfg_t;

  // one classified report, handed from front to back
  typedef struct packed {
    logic [MOD_EVT_N-1:0]      mod_chg;
    logic [MOD_EVT_N-1:0]      mod_val;
    logic                      remap;
    logic [KEY_CODE_COUNT-1:0] diff;
    logic [KEY_CODE_COUNT-1:0] now;
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_e;

  function automatic logic [POS_W-1:0] lowest_set(input logic [WIN_W-1:0] v);
    logic [POS_W-1:0] pos;
    pos = '0;
    for (int i = WIN_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = POS_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

@@ src/hidkbd_if.sv @@
// report and key event channel interfaces
interface hidkbd_report_if;
  logic        valid;
  logic        ready;
  logic [7:0]  modifier_bits;
  logic [7:0]  slot0;
  logic [7:0]  slot1;
  logic [7:0]  slot2;
  logic [7:0]  slot3;
  logic [7:0]  slot4;
  logic [7:0]  slot5;
  logic        menu_active;

  modport source (
    output valid, modifier_bits, slot0, slot1, slot2, slot3, slot4, slot5, menu_active,
    input  ready
  );
  modport sink (
    input  valid, modifier_bits, slot0, slot1, slot2, slot3, slot4, slot5, menu_active,
    output ready
  );
endinterface

interface hidkbd_event_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;
  logic       pressed;
  logic       last_event;

  modport source (
    output valid, key_code, pressed, last_event,
    input  ready
  );
  modport sink (
    input  valid, key_code, pressed, last_event,
    output ready
  );
endinterface

@@ src/hidkbd_front.sv @@
// front end: accepts reports, diffs them against the stored state, builds a job
module hidkbd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  hidkbd_report_if.sink      report_i,
  input  logic               push_ready_i,
  output logic               push_valid_o,
  output hidkbd_pkg::job_t   push_job_o
);
  import hidkbd_pkg::*;

  logic [KEY_CODE_COUNT-1:0] map_q, map_d;
  logic [7:0]                prev_mod_q;
  logic                      shift_remap_q, shift_remap_d;
  logic [CODE_W-1:0]         slots [REPORT_SLOTS];
  logic [KEY_CODE_COUNT-1:0] now;
  logic [7:0]                mod_cur, mod_chg;
  logic                      accept;

  assign accept = report_i.valid && push_ready_i;
  assign report_i.ready = push_ready_i;
  assign push_valid_o = report_i.valid;

  assign slots[0] = report_i.slot0;
  assign slots[1] = report_i.slot1;
  assign slots[2] = report_i.slot2;
  assign slots[3] = report_i.slot3;
  assign slots[4] = report_i.slot4;
  assign slots[5] = report_i.slot5;

  assign mod_cur = report_i.modifier_bits;
  assign mod_chg = mod_cur ^ prev_mod_q;

  always_comb begin
    now = '0;
    for (int s = 0; s < REPORT_SLOTS; s++) begin
      // empty slots and out of range codes are ignored
      if ((slots[s] != '0) && ({1'b0, slots[s]} < (CODE_W + 1)'(KEY_CODE_COUNT))) begin
        now[slots[s][KEY_W-1:0]] = 1'b1;
      end
    end
  end

  always_comb begin
    shift_remap_d = shift_remap_q;
    // right shift is handled after left shift, so it wins
    if (report_i.menu_active) begin
      if (mod_chg[1]) begin
        shift_remap_d = mod_cur[1];
      end
      if (mod_chg[5]) begin
        shift_remap_d = mod_cur[5];
      end
    end
    map_d = now;
  end

  always_comb begin
    push_job_o.mod_chg = {mod_chg[5], mod_chg[3], mod_chg[1], mod_chg[0]};
    push_job_o.mod_val = {mod_cur[5], mod_cur[3], mod_cur[1], mod_cur[0]};
    push_job_o.remap   = report_i.menu_active && shift_remap_d;
    push_job_o.diff    = (map_q ^ now) & ~KEY_CODE_COUNT'(1);
    push_job_o.now     = now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q         <= '0;
      prev_mod_q    <= '0;
      shift_remap_q <= 1'b0;
    end else if (accept) begin
      map_q         <= map_d;
      prev_mod_q    <= mod_cur;
      shift_remap_q <= shift_remap_d;
    end
  end

endmodule

@@ src/hidkbd_queue.sv @@
// short job queue between front and back
module hidkbd_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_valid_i,
  output logic                          push_ready_o,
  input  hidkbd_pkg::job_t              push_job_i,
  output logic                          pop_valid_o,
  input  logic                          pop_i,
  output hidkbd_pkg::job_t              pop_job_o,
  output logic [hidkbd_pkg::QCNT_W-1:0] count_o
);
  import hidkbd_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign count_o      = count_q;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ src/hidkbd_back.sv @@
// back end: walks one job and emits its events through an output register
module hidkbd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hidkbd_pkg::cfg_t   cfg_i,
  input  logic               pop_valid_i,
  output logic               pop_o,
  input  hidkbd_pkg::job_t   pop_job_i,
  output logic               busy_o,
  hidkbd_event_if.source     event_o
);
  import hidkbd_pkg::*;

  bk_state_e                 state_q, state_d;
  logic [MOD_EVT_N-1:0]      mod_pend_q, mod_pend_d;
  logic [MOD_EVT_N-1:0]      mod_val_q, mod_val_d;
  logic                      remap_q, remap_d;
  logic [KEY_CODE_COUNT-1:0] diff_q, diff_d;
  logic [KEY_CODE_COUNT-1:0] now_q, now_d;
  logic [WIN_IDX_W-1:0]      win_q, win_d;
  logic                      out_valid_q, out_valid_d;
  logic [CODE_W-1:0]         out_code_q, out_code_d;
  logic                      out_pressed_q, out_pressed_d;
  logic                      out_last_q, out_last_d;

  logic [1:0]                mod_idx;
  logic [MOD_EVT_N-1:0]      mod_rest;
  logic [WIN_W-1:0]          win_bits;
  logic [POS_W-1:0]          pos;
  logic [KEY_W-1:0]          key;
  logic [KEY_CODE_COUNT-1:0] diff_clr;
  logic                      can_emit;
  logic [CODE_W-1:0]         mod_code, key_code;

  always_comb begin
    if (mod_pend_q[0]) begin
      mod_idx = 2'd0;
    end else if (mod_pend_q[1]) begin
      mod_idx = 2'd1;
    end else if (mod_pend_q[2]) begin
      mod_idx = 2'd2;
    end else begin
      mod_idx = 2'd3;
    end
  end

  assign mod_rest = mod_pend_q & ~(MOD_EVT_N'(1) << mod_idx);

  always_comb begin
    case (mod_idx)
      2'(MOD_LCTRL):  mod_code = cfg_i.code_left_control;
      2'(MOD_LSHIFT): mod_code = cfg_i.code_left_shift;
      2'(MOD_LALT):   mod_code = cfg_i.code_left_alt;
      2'(MOD_RSHIFT): mod_code = cfg_i.code_right_shift;
      default:        mod_code = cfg_i.code_right_shift;
    endcase
  end

  assign win_bits = diff_q[win_q*WIN_W +: WIN_W];
  assign pos      = lowest_set(win_bits);
  assign key      = {win_q, pos};
  assign diff_clr = diff_q & ~(KEY_CODE_COUNT'(1) << key);

  // right remap takes precedence when both indexes match
  always_comb begin
    key_code = CODE_W'(key);
    if (remap_q) begin
      if (CODE_W'(key) == CODE_W'(cfg_i.code_right)) begin
        key_code = cfg_i.code_left;
      end else if (CODE_W'(key) == CODE_W'(cfg_i.code_down)) begin
        key_code = cfg_i.code_up;
      end
    end
  end

  assign can_emit = !out_valid_q || event_o.ready;

  always_comb begin
    state_d       = state_q;
    mod_pend_d    = mod_pend_q;
    mod_val_d     = mod_val_q;
    remap_d       = remap_q;
    diff_d        = diff_q;
    now_d         = now_q;
    win_d         = win_q;
    out_valid_d   = out_valid_q && !event_o.ready;
    out_code_d    = out_code_q;
    out_pressed_d = out_pressed_q;
    out_last_d    = out_last_q;
    pop_o         = 1'b0;

    case (state_q)
      BK_IDLE: begin
        if (pop_valid_i) begin
          pop_o      = 1'b1;
          mod_pend_d = pop_job_i.mod_chg;
          mod_val_d  = pop_job_i.mod_val;
          remap_d    = pop_job_i.remap;
          diff_d     = pop_job_i.diff;
          now_d      = pop_job_i.now;
          win_d      = '0;
          state_d    = BK_RUN;
        end
      end
      BK_RUN: begin
        if (|mod_pend_q) begin
          if (can_emit) begin
            mod_pend_d    = mod_rest;
            out_valid_d   = 1'b1;
            out_code_d    = mod_code;
            out_pressed_d = mod_val_q[mod_idx];
            out_last_d    = !(|mod_rest) && !(|diff_q);
            if (out_last_d) begin
              state_d = BK_IDLE;
            end
          end
        end else if (|win_bits) begin
          if (can_emit) begin
            diff_d        = diff_clr;
            out_valid_d   = 1'b1;
            out_code_d    = key_code;
            out_pressed_d = now_q[key];
            out_last_d    = !(|diff_clr);
            if (out_last_d) begin
              state_d = BK_IDLE;
            end
          end
        end else if (|diff_q) begin
          win_d = win_q + 1'b1;
        end else begin
          // report with no change
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_pend_q    <= mod_pend_d;
    mod_val_q     <= mod_val_d;
    remap_q       <= remap_d;
    diff_q        <= diff_d;
    now_q         <= now_d;
    win_q         <= win_d;
    out_code_q    <= out_code_d;
    out_pressed_q <= out_pressed_d;
    out_last_q    <= out_last_d;
  end

  assign busy_o             = (state_q == BK_RUN);
  assign event_o.valid      = out_valid_q;
  assign event_o.key_code   = out_code_q;
  assign event_o.pressed    = out_pressed_q;
  assign event_o.last_event = out_last_q;

endmodule

@@ src/hid_keyboard_report_to_key_events_top.sv @@
// top level: keyboard report to key event converter with register port
// Converts USB boot keyboard reports into press and release key events. Each accepted report
// beat is compared with the previous report: modifier events come first (left control, left
// shift, left alt, right shift, using the configured codes), then key events in ascending key
// index 1..127; the final event of a report carries last_event, and a report that changes
// nothing produces no event beats. While menu_active is set, shift changes set or clear a
// remap flag, and with both set the configured right and down keys report as left and up.
// The front end takes a report and hands a job into a two-entry queue; the back end emits one
// event per cycle through an output register while the receiver is ready and no window step
// comes between, and steps through the 128-key difference map in 16-key windows. A report
// yields at most 16 events, and reports keep being accepted while the queue has room.
// Registers sit at byte address 4*index on the APB port.
module hid_keyboard_report_to_key_events_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  hidkbd_report_if.sink                     report_i,
  hidkbd_event_if.source                    event_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hidkbd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [hidkbd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [hidkbd_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready
);
  import hidkbd_pkg::*;

  cfg_t              cfg_q;
  cfg_reg_e          reg_idx;
  logic              cfg_wr;

  // front to queue, queue to back
  logic              push_valid, push_ready;
  job_t              push_job;
  logic              pop_valid, pop;
  job_t              pop_job;
  logic [QCNT_W-1:0] q_count;
  logic              back_busy;

  // register port: no wait states, register index from the word address
  assign pready  = 1'b1;
  assign reg_idx = cfg_reg_e'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_left_control <= RST_CODE_LEFT_CONTROL;
      cfg_q.code_left_shift   <= RST_CODE_LEFT_SHIFT;
      cfg_q.code_right_shift  <= RST_CODE_RIGHT_SHIFT;
      cfg_q.code_left_alt     <= RST_CODE_LEFT_ALT;
      cfg_q.code_right        <= RST_CODE_RIGHT;
      cfg_q.code_left         <= RST_CODE_LEFT;
      cfg_q.code_down         <= RST_CODE_DOWN;
      cfg_q.code_up           <= RST_CODE_UP;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CODE_LEFT_CONTROL: cfg_q.code_left_control <= pwdata[7:0];
        REG_CODE_LEFT_SHIFT:   cfg_q.code_left_shift   <= pwdata[7:0];
        REG_CODE_RIGHT_SHIFT:  cfg_q.code_right_shift  <= pwdata[7:0];
        REG_CODE_LEFT_ALT:     cfg_q.code_left_alt     <= pwdata[7:0];
        REG_CODE_RIGHT:        cfg_q.code_right        <= pwdata[6:0];
        REG_CODE_LEFT:         cfg_q.code_left         <= pwdata[7:0];
        REG_CODE_DOWN:         cfg_q.code_down         <= pwdata[6:0];
        REG_CODE_UP:           cfg_q.code_up           <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read data, zero extended
  always_comb begin
    case (reg_idx)
      REG_CODE_LEFT_CONTROL: prdata = APB_DATA_W'(cfg_q.code_left_control);
      REG_CODE_LEFT_SHIFT:   prdata = APB_DATA_W'(cfg_q.code_left_shift);
      REG_CODE_RIGHT_SHIFT:  prdata = APB_DATA_W'(cfg_q.code_right_shift);
      REG_CODE_LEFT_ALT:     prdata = APB_DATA_W'(cfg_q.code_left_alt);
      REG_CODE_RIGHT:        prdata = APB_DATA_W'(cfg_q.code_right);
      REG_CODE_LEFT:         prdata = APB_DATA_W'(cfg_q.code_left);
      REG_CODE_DOWN:         prdata = APB_DATA_W'(cfg_q.code_down);
      REG_CODE_UP:           prdata = APB_DATA_W'(cfg_q.code_up);
      default:               prdata = '0;
    endcase
  end

  // front end: owns the pressed map, previous modifiers and shift flag
  hidkbd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .report_i     (report_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_job_o   (push_job)
  );

  // decouples report intake from event emission
  hidkbd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_job_o    (pop_job),
    .count_o      (q_count)
  );

  // back end: serializes events, applies configured codes and the cursor remap
  hidkbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_job_i   (pop_job),
    .busy_o      (back_busy),
    .event_o     (event_o)
  );

  // an accepted report is held in the queue on the next cycle
  a_report_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (report_i.valid && report_i.ready) |=> (q_count != '0))
    else $error("accepted report not held in queue");

  // after a non-final event beat the report still has events to deliver
  a_more_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_o.valid && event_o.ready && !event_o.last_event) |=> (back_busy || event_o.valid))
    else $error("report ended without a final event");

  // queue occupancy stays within its depth
  a_queue_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count <= QCNT_W'(QUEUE_DEPTH)))
    else $error("job queue overflow");

endmodule

@@ bench/testbench.sv @@
// self-checking bench for the keyboard report to key event converter
module testbench;
  import hidkbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // clock, reset and run limits
  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 64;       // lets a report in flight finish
  localparam int LONG_HOLD      = 300;      // receiver back-pressure stretch, in cycles
  localparam int IDLE_PERCENT   = 16;
  localparam int TIMEOUT_NS     = 5_000_000;
  localparam int MAX_EVENTS     = 16;

  // modifier byte bit positions that produce events
  localparam int LCTRL_BIT  = 0;
  localparam int LSHIFT_BIT = 1;
  localparam int LALT_BIT   = 3;
  localparam int RSHIFT_BIT = 5;
  localparam logic [7:0] LSHIFT_MASK = 8'(1 << LSHIFT_BIT);
  localparam logic [7:0] RSHIFT_MASK = 8'(1 << RSHIFT_BIT);

  typedef struct packed {
    logic [7:0]                   mods;
    logic [REPORT_SLOTS-1:0][7:0] slots;
    logic                         menu;
  } kbd_report_t;

  typedef struct packed {
    logic [7:0] code;
    logic       pressed;
    logic       last;
  } key_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // register port
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  hidkbd_report_if rep ();
  hidkbd_event_if  ev ();

  hid_keyboard_report_to_key_events_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .report_i (rep),
    .event_o  (ev),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // predictor state: mirror of the key codes and the block's report history
  cfg_t                      key_codes;
  logic [KEY_CODE_COUNT-1:0] keys_held;
  logic [7:0]                prev_mods;
  logic                      shift_remap;

  kbd_report_t pending_reports[$];   // reports waiting for the driver
  key_event_t  expected_events[$];   // events predicted but not yet seen
  kbd_report_t last_queued;

  // shared between stimulus, driver and sink
  bit no_idle       = 1'b0;
  int hold_requests = 0;
  bit rep_taken     = 1'b0;

  int error_count      = 0;
  int reports_accepted = 0;
  int event_beats      = 0;
  int reg_writes       = 0;
  int settings_used    = 0;

  // ---------------------------------------------------------------------------
  // predictor: turns one accepted report into its press/release events
  // modifier events first in bit order, then keys 1..127 ascending
  // ---------------------------------------------------------------------------
  task automatic predict_key_events(input kbd_report_t r);
    key_event_t                evs[$];
    key_event_t                e;
    logic [KEY_CODE_COUNT-1:0] now_held;
    logic [7:0]                code;
    bit                        is_mod;
    now_held = '0;
    for (int b = 0; b < 8; b++) begin
      is_mod = 1'b1;
      case (b)
        LCTRL_BIT:  code = key_codes.code_left_control;
        LSHIFT_BIT: code = key_codes.code_left_shift;
        LALT_BIT:   code = key_codes.code_left_alt;
        RSHIFT_BIT: code = key_codes.code_right_shift;
        default:    is_mod = 1'b0;   // unused bits are stored but silent
      endcase
      if (is_mod && r.mods[b] != prev_mods[b]) begin
        // shift changes only steer the remap flag while the menu is up
        if ((b == LSHIFT_BIT || b == RSHIFT_BIT) && r.menu) begin
          shift_remap = r.mods[b];
        end
        e.code    = code;
        e.pressed = r.mods[b];
        e.last    = 1'b0;
        evs.push_back(e);
      end
    end
    prev_mods = r.mods;

    // empty slots and codes beyond the map are dropped, duplicates collapse
    for (int s = 0; s < REPORT_SLOTS; s++) begin
      if (r.slots[s] != 8'd0 && r.slots[s] < KEY_CODE_COUNT) begin
        now_held[r.slots[s][KEY_W-1:0]] = 1'b1;
      end
    end

    for (int k = 1; k < KEY_CODE_COUNT; k++) begin
      if (keys_held[k] != now_held[k]) begin
        code = 8'(k);
        // right remap wins when both remap keys are the same index
        if (r.menu && shift_remap) begin
          if (KEY_W'(k) == key_codes.code_right) begin
            code = key_codes.code_left;
          end else if (KEY_W'(k) == key_codes.code_down) begin
            code = key_codes.code_up;
          end
        end
        if (evs.size() < MAX_EVENTS) begin
          e.code    = code;
          e.pressed = now_held[k];
          e.last    = 1'b0;
          evs.push_back(e);
        end
      end
    end
    keys_held = now_held;

    if (evs.size() > 0) begin
      evs[evs.size()-1].last = 1'b1;
    end
    foreach (evs[i]) begin
      expected_events.push_back(evs[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // register access: write, then read back, and track the value
  // ---------------------------------------------------------------------------
  task automatic write_code_reg(input cfg_reg_e idx, input logic [7:0] value);
    logic [APB_DATA_W-1:0] readback;
    logic [7:0]            stored;
    stored = (idx == REG_CODE_RIGHT || idx == REG_CODE_DOWN) ? {1'b0, value[6:0]} : value;
    // setup then access phase of the write
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= APB_DATA_W'(stored);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // read back from the same address
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;

    case (idx)
      REG_CODE_LEFT_CONTROL: key_codes.code_left_control = stored;
      REG_CODE_LEFT_SHIFT:   key_codes.code_left_shift   = stored;
      REG_CODE_RIGHT_SHIFT:  key_codes.code_right_shift  = stored;
      REG_CODE_LEFT_ALT:     key_codes.code_left_alt     = stored;
      REG_CODE_RIGHT:        key_codes.code_right        = stored[6:0];
      REG_CODE_LEFT:         key_codes.code_left         = stored;
      REG_CODE_DOWN:         key_codes.code_down         = stored[6:0];
      REG_CODE_UP:           key_codes.code_up           = stored;
      default: ;
    endcase
    reg_writes++;
    if (readback !== APB_DATA_W'(stored)) begin
      error_count++;
      $display("%0t: register %s readback expected %0d actual %0d",
               $time, idx.name(), stored, readback);
    end
  endtask

  task automatic set_key_codes(input logic [7:0] lctrl, lshift, rshift, lalt,
                               input logic [7:0] right_key, left_code, down_key, up_code);
    write_code_reg(REG_CODE_LEFT_CONTROL, lctrl);
    write_code_reg(REG_CODE_LEFT_SHIFT, lshift);
    write_code_reg(REG_CODE_RIGHT_SHIFT, rshift);
    write_code_reg(REG_CODE_LEFT_ALT, lalt);
    write_code_reg(REG_CODE_RIGHT, right_key);
    write_code_reg(REG_CODE_LEFT, left_code);
    write_code_reg(REG_CODE_DOWN, down_key);
    write_code_reg(REG_CODE_UP, up_code);
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // report generation
  // ---------------------------------------------------------------------------
  function automatic kbd_report_t make_report(input logic [7:0] mods,
                                              input logic [7:0] s0, s1, s2, s3, s4, s5,
                                              input logic menu);
    kbd_report_t r;
    r.mods  = mods;
    r.slots = {s5, s4, s3, s2, s1, s0};
    r.menu  = menu;
    return r;
  endfunction

  // mostly a plausible next report: keys held over, shift toggles, remap keys
  // favored; some pure noise and some exact repeats
  function automatic kbd_report_t next_random_report(input kbd_report_t prev_rep);
    kbd_report_t r;
    int          pick;
    r    = prev_rep;
    pick = $urandom_range(99);
    if (pick < 8) begin
      return r;
    end
    if (pick < 18) begin
      r.mods  = 8'($urandom);
      r.slots = (REPORT_SLOTS * 8)'({$urandom, $urandom});
      r.menu  = 1'($urandom);
      return r;
    end
    case ($urandom_range(2))
      0:       r.mods = prev_rep.mods;
      1:       r.mods = prev_rep.mods ^ ($urandom_range(1) ? LSHIFT_MASK : RSHIFT_MASK);
      default: r.mods = 8'($urandom);
    endcase
    r.menu = ($urandom_range(99) < 75);
    for (int s = 0; s < REPORT_SLOTS; s++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: r.slots[s] = prev_rep.slots[s];
        4:          r.slots[s] = 8'd0;
        5:          r.slots[s] = 8'($urandom_range(KEY_CODE_COUNT, 255));
        6:          r.slots[s] = {1'b0, key_codes.code_right};
        7:          r.slots[s] = {1'b0, key_codes.code_down};
        default:    r.slots[s] = 8'($urandom_range(1, KEY_CODE_COUNT - 1));
      endcase
    end
    return r;
  endfunction

  task automatic queue_report(input kbd_report_t r);
    pending_reports.push_back(r);
    last_queued = r;
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      queue_report(next_random_report(last_queued));
    end
  endtask

  // wait until every report is in and every predicted event has come out
  task automatic drain_events(input bit settle);
    while (pending_reports.size() != 0 || expected_events.size() != 0) begin
      @(posedge clk_i);
    end
    if (settle) begin
      // a report with no events may still be in the back end
      repeat (SETTLE_CYCLES) @(posedge clk_i);
    end
  endtask

  // ---------------------------------------------------------------------------
  // report driver: acceptance is seen at the rising edge, new beats go out
  // at the falling edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rep_taken = rst_ni && rep.valid && rep.ready;
    if (rep_taken) begin
      predict_key_events(make_report(rep.modifier_bits, rep.slot0, rep.slot1, rep.slot2,
                                     rep.slot3, rep.slot4, rep.slot5, rep.menu_active));
      void'(pending_reports.pop_front());
      reports_accepted++;
    end
  end

  always @(negedge clk_i) begin
    // a beat on offer stays put until it is taken
    if (rst_ni && (!rep.valid || rep_taken)) begin
      if (pending_reports.size() > 0 &&
          (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
        rep.modifier_bits <= pending_reports[0].mods;
        rep.slot0         <= pending_reports[0].slots[0];
        rep.slot1         <= pending_reports[0].slots[1];
        rep.slot2         <= pending_reports[0].slots[2];
        rep.slot3         <= pending_reports[0].slots[3];
        rep.slot4         <= pending_reports[0].slots[4];
        rep.slot5         <= pending_reports[0].slots[5];
        rep.menu_active   <= pending_reports[0].menu;
        rep.valid         <= 1'b1;
      end else begin
        rep.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // event sink: random ready, plus a long hold when the stimulus asks for one
  // ---------------------------------------------------------------------------
  int hold_served = 0;
  int hold_left   = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      ev.ready <= 1'b0;
    end else begin
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        ev.ready <= 1'b0;
      end else begin
        ev.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // event monitor: every beat is checked against the oldest prediction
  key_event_t seen_event;
  key_event_t want_event;

  always @(posedge clk_i) begin
    if (rst_ni && ev.valid && ev.ready) begin
      event_beats++;
      seen_event.code    = ev.key_code;
      seen_event.pressed = ev.pressed;
      seen_event.last    = ev.last_event;
      if (expected_events.size() == 0) begin
        error_count++;
        $display("%0t: unexpected event beat, expected none, actual code %0d pressed %0b last %0b",
                 $time, seen_event.code, seen_event.pressed, seen_event.last);
      end else begin
        want_event = expected_events.pop_front();
        if (seen_event.code !== want_event.code ||
            seen_event.pressed !== want_event.pressed ||
            seen_event.last !== want_event.last) begin
          error_count++;
          $display("%0t: event mismatch, expected code %0d pressed %0b last %0b, actual code %0d pressed %0b last %0b",
                   $time, want_event.code, want_event.pressed, want_event.last,
                   seen_event.code, seen_event.pressed, seen_event.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: register settings in phases, directed reports, then random ones
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] rk;
    logic [7:0] dk;
    logic [7:0] shared_key;

    // every input known from the first instant
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    rep.valid         = 1'b0;
    rep.modifier_bits = '0;
    rep.slot0         = '0;
    rep.slot1         = '0;
    rep.slot2         = '0;
    rep.slot3         = '0;
    rep.slot4         = '0;
    rep.slot5         = '0;
    rep.menu_active   = 1'b0;
    ev.ready          = 1'b0;

    key_codes   = '{code_left_control: RST_CODE_LEFT_CONTROL,
                    code_left_shift:   RST_CODE_LEFT_SHIFT,
                    code_right_shift:  RST_CODE_RIGHT_SHIFT,
                    code_left_alt:     RST_CODE_LEFT_ALT,
                    code_right:        RST_CODE_RIGHT,
                    code_left:         RST_CODE_LEFT,
                    code_down:         RST_CODE_DOWN,
                    code_up:           RST_CODE_UP};
    keys_held   = '0;
    prev_mods   = '0;
    shift_remap = 1'b0;
    last_queued = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // phase 1: default codes, directed corner reports
    set_key_codes(RST_CODE_LEFT_CONTROL, RST_CODE_LEFT_SHIFT, RST_CODE_RIGHT_SHIFT,
                  RST_CODE_LEFT_ALT, {1'b0, RST_CODE_RIGHT}, RST_CODE_LEFT,
                  {1'b0, RST_CODE_DOWN}, RST_CODE_UP);
    rk = {1'b0, key_codes.code_right};
    dk = {1'b0, key_codes.code_down};
    queue_report(make_report(8'h00, 0, 0, 0, 0, 0, 0, 0));          // nothing changes
    queue_report(make_report(8'hFF, 0, 0, 0, 0, 0, 0, 0));          // all modifiers down
    queue_report(make_report(8'hD4, 0, 0, 0, 0, 0, 0, 0));          // unused bits stay up
    queue_report(make_report(8'h00, 0, 0, 0, 0, 0, 0, 0));          // only unused bits drop
    queue_report(make_report(8'h00, 1, 127, 255, 128, 0, 1, 0));    // extremes, dup, overrange
    queue_report(make_report(8'h2B, 2, 3, 4, 5, 6, 7, 0));
    queue_report(make_report(8'h00, 8, 9, 10, 11, 12, 13, 0));      // sixteen events
    queue_report(make_report(8'h00, 8, 9, 10, 11, 12, 13, 0));      // repeat, no events
    queue_report(make_report(8'h00, 0, 0, 0, 0, 0, 0, 1));
    queue_report(make_report(LSHIFT_MASK, rk, dk, 0, 0, 0, 0, 1));  // shift sets remap
    queue_report(make_report(RSHIFT_MASK, rk, 0, 0, 0, 0, 0, 1));   // both shifts swap
    queue_report(make_report(LSHIFT_MASK, rk, dk, 0, 0, 0, 0, 1));  // right shift clears last
    queue_report(make_report(8'h00, 0, 0, 0, 0, 0, 0, 0));          // menu off, flag untouched
    queue_report(make_report(LSHIFT_MASK, 0, 0, 0, 0, 0, 0, 0));
    queue_report(make_report(LSHIFT_MASK, rk, 0, 0, 0, 0, 0, 1));
    queue_report(make_report(8'h00, rk, 0, 0, 0, 0, 0, 1));
    queue_report(make_report(RSHIFT_MASK, 0, 0, 0, 0, 0, 0, 1));
    queue_report(make_report(RSHIFT_MASK, dk, rk, 0, 0, 0, 0, 0));  // flag set, menu off
    queue_report(make_report(RSHIFT_MASK, 0, 0, 0, 0, 0, 0, 1));     // remapped releases
    queue_report(make_report(8'h00, 127, 0, 0, 0, 0, 0, 1));
    queue_report(make_report(8'h00, 0, 0, 0, 0, 0, 0, 0));
    queue_random(80);
    drain_events(1'b1);

    // phase 2: extreme codes, no idling on either side
    set_key_codes(8'd0, 8'd255, 8'd0, 8'd255, 8'd127, 8'd0, 8'd1, 8'd255);
    no_idle = 1'b1;
    queue_random(60);
    drain_events(1'b1);
    no_idle = 1'b0;

    // phase 3: both remap keys on the same index, right remap has priority
    shared_key = 8'($urandom_range(1, KEY_CODE_COUNT - 1));
    set_key_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  shared_key, 8'($urandom), shared_key, 8'($urandom));
    queue_report(make_report(8'h00, 0, 0, 0, 0, 0, 0, 1));
    queue_report(make_report(LSHIFT_MASK, shared_key, 0, 0, 0, 0, 0, 1));
    queue_report(make_report(LSHIFT_MASK, 0, 0, 0, 0, 0, 0, 1));
    queue_random(60);
    drain_events(1'b1);

    // phase 4: down key on index zero, which is never scanned
    set_key_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom_range(1, KEY_CODE_COUNT - 1)), 8'($urandom), 8'd0,
                  8'($urandom));
    queue_report(make_report(LSHIFT_MASK, 1, 0, 0, 0, 0, 0, 1));
    queue_random(60);
    drain_events(1'b1);

    // phase 5: random codes; receiver holds off while reports keep coming,
    // then the sender waits out every event before the second half
    set_key_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom_range(1, KEY_CODE_COUNT - 1)), 8'($urandom),
                  8'($urandom_range(1, KEY_CODE_COUNT - 1)), 8'($urandom));
    hold_requests++;
    queue_random(55);
    drain_events(1'b0);
    queue_random(55);
    drain_events(1'b1);

    $display("covered %0d reports and %0d key event beats over %0d code settings",
             reports_accepted, event_beats, settings_used);
    $display("with %0d register writes read back, one long receiver hold and one sender pause",
             reg_writes);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #TIMEOUT_NS;
    $display("timeout with %0d reports pending and %0d events outstanding",
             pending_reports.size(), expected_events.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
